[rtl/core/lbws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbws_pkg: shared types and constants for the Legendre band window sum unit
// Field widths, status codes, the queued command word and the Q30 clamp.
// ----------------------------------------------------------------------------
package lbws_pkg;

	// Fixed field widths
	localparam int MP_W = 10;      // multipole fields
	localparam int X_W = 32;       // angle cosine, P_k values
	localparam int SUM_W = 32;     // band_sum output
	localparam int ST_W = 2;       // status output
	localparam int FRAC_W = 30;    // Q30 fraction bits

	// Quotient bits of the two dividers (magnitude bounds of the quotients)
	localparam int TERM_QUO_W = 28;
	localparam int REC_QUO_W = X_W;

	// Parameter defaults
	localparam int MAX_MULTIPOLE_DEF = 1023;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic signed [X_W-1:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [X_W:0] ONE_WIDE = 33'sh0_4000_0000;
	localparam logic signed [X_W:0] NEG_ONE_WIDE = -ONE_WIDE;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FIRST_ZERO = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT = 2'd2;

	// Classification of an accepted word
	typedef enum logic [1:0] {
		CMD_RUN   = 2'd0,
		CMD_ZERO  = 2'd1,
		CMD_EMPTY = 2'd2
	} cmd_kind_t;

	// Command word passed from front to back
	typedef struct packed {
		cmd_kind_t              kind;
		logic signed [X_W-1:0]  x;
		logic [MP_W-1:0]        first;
		logic [MP_W-1:0]        last;
	} cmd_t;

	// Clamp a value to [-1.0, 1.0] in Q30
	function automatic logic signed [X_W-1:0] clamp_q30(input logic signed [X_W:0] v);
		logic signed [X_W-1:0] r;
		if (v > ONE_WIDE) begin
			r = ONE_Q30;
		end else if (v < NEG_ONE_WIDE) begin
			r = -ONE_Q30;
		end else begin
			r = v[X_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/lbws_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbws_front: input word classification
// Clamps the cosine and the last multipole, sorts each word into run, zero
// or empty band, and pushes it into the command queue.
// ----------------------------------------------------------------------------
module lbws_front import lbws_pkg::*; #(
	parameter int MAX_MULTIPOLE = MAX_MULTIPOLE_DEF
) (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [X_W-1:0]  angle_cosine,
	input  logic [MP_W-1:0]        first_multipole,
	input  logic [MP_W-1:0]        last_multipole,
	input  logic                   q_full,
	output logic                   q_push,
	output cmd_t                   q_cmd
);

	logic [MP_W-1:0] last_sat;

	// Last multipole limited to the configured maximum
	always_comb begin
		if (32'(last_multipole) > 32'(MAX_MULTIPOLE)) begin
			last_sat = MP_W'(MAX_MULTIPOLE);
		end else begin
			last_sat = last_multipole;
		end
	end

	// Build the command word
	always_comb begin
		q_cmd.x = clamp_q30({angle_cosine[X_W-1], angle_cosine});
		q_cmd.first = first_multipole;
		q_cmd.last = last_sat;
		if (first_multipole == '0) begin
			q_cmd.kind = CMD_ZERO;
		end else if (first_multipole > last_sat) begin
			q_cmd.kind = CMD_EMPTY;
		end else begin
			q_cmd.kind = CMD_RUN;
		end
	end

	// Accept whenever the queue has room
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

endmodule

[rtl/core/lbws_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbws_cmd_queue: command queue between front and back
// Small register FIFO; lets the front keep accepting while the back works.
// ----------------------------------------------------------------------------
module lbws_cmd_queue import lbws_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output cmd_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t           entry_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = entry_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

[rtl/core/lbws_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbws_div: bit-serial rounding divider
// Signed numerator over positive denominator, rounded to nearest with halves
// away from zero. One quotient bit per cycle; the caller guarantees that the
// quotient magnitude fits in QUO_W bits.
// ----------------------------------------------------------------------------
module lbws_div import lbws_pkg::*; #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 23,
	parameter int QUO_W = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]          den,
	output logic                      busy,
	output logic signed [QUO_W:0]     quot
);

	localparam int AW = NUM_W + 1;
	localparam int CNT_W = $clog2(QUO_W + 1);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_ADJ  = 4'b0010,
		D_ITER = 4'b0100,
		D_SIGN = 4'b1000
	} div_state_t;

	div_state_t             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic [NUM_W-1:0]       mag_q;
	logic [DEN_W-1:0]       den_q;
	logic [DEN_W-1:0]       rem_q;
	logic [QUO_W-1:0]       low_q;
	logic signed [QUO_W:0]  quot_q;

	logic [NUM_W-1:0]       mag;
	logic [AW-1:0]          adj;
	logic [DEN_W:0]         rem_sh;
	logic [DEN_W:0]         diff;
	logic                   ge;

	// Magnitude, rounding offset and one restoring step
	always_comb begin
		mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		adj = AW'(mag_q) + AW'(den_q >> 1);
		rem_sh = {rem_q, low_q[QUO_W-1]};
		diff = rem_sh - {1'b0, den_q};
		ge = (rem_sh >= {1'b0, den_q});
	end

	assign busy = (state_q != D_IDLE);
	assign quot = quot_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_ADJ;
					end
				end
				D_ADJ: begin
					cnt_q <= CNT_W'(QUO_W);
					state_q <= D_ITER;
				end
				D_ITER: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= D_SIGN;
					end
				end
				D_SIGN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= num[NUM_W-1];
					mag_q <= mag;
					den_q <= den;
				end
			end
			D_ADJ: begin
				rem_q <= DEN_W'(adj >> QUO_W);
				low_q <= adj[QUO_W-1:0];
			end
			D_ITER: begin
				rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				low_q <= {low_q[QUO_W-2:0], ge};
			end
			D_SIGN: begin
				quot_q <= neg_q ? -$signed({1'b0, low_q}) : $signed({1'b0, low_q});
			end
			default: begin
				quot_q <= quot_q;
			end
		endcase
	end

endmodule

[rtl/core/lbws_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbws_back: Legendre recurrence and band accumulation
// Steps the three-term recurrence one degree at a time, adds the weighted
// term for degrees inside the band, saturates and registers the result word.
// ----------------------------------------------------------------------------
module lbws_back import lbws_pkg::*; #(
	parameter int MAX_MULTIPOLE = MAX_MULTIPOLE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  cmd_t                     q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SUM_W-1:0]  band_sum,
	output logic [ST_W-1:0]          status
);

	localparam int KW = $clog2(MAX_MULTIPOLE + 1);
	localparam int ODD_W = KW + 1;
	localparam int TDEN_W = 2 * KW + 3;
	localparam int PROD_W = KW + 34;
	localparam int KP_W = KW + 33;
	localparam int ACC_W = KW + 34;
	localparam logic signed [2*X_W-1:0] XROUND = (2 * X_W)'(1) << (FRAC_W - 1);
	localparam logic signed [ACC_W-1:0] SUM_HI =
		{{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SUM_LO =
		{{(ACC_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_TMUL = 9'b000000010,
		S_XMUL = 9'b000000100,
		S_XRND = 9'b000001000,
		S_AMUL = 9'b000010000,
		S_RNUM = 9'b000100000,
		S_RDIV = 9'b001000000,
		S_WAIT = 9'b010000000,
		S_FIN  = 9'b100000000
	} back_state_t;

	back_state_t                 state_q;
	logic                        out_valid_q;
	logic signed [SUM_W-1:0]     band_sum_q;
	logic [ST_W-1:0]             status_q;

	logic [KW-1:0]               k_q;
	logic [ODD_W-1:0]            odd_q;
	logic [TDEN_W-1:0]           tden_q;
	logic [MP_W-1:0]             first_q;
	logic [KW-1:0]               last_q;
	logic                        zero_q;
	logic signed [X_W-1:0]       x_q;
	logic signed [X_W-1:0]       p_prev_q;
	logic signed [X_W-1:0]       p_cur_q;
	logic signed [PROD_W-1:0]    tnum_q;
	logic signed [2*X_W-1:0]     xprod_q;
	logic signed [X_W-1:0]       xp_q;
	logic signed [PROD_W-1:0]    a_q;
	logic signed [PROD_W-1:0]    rnum_q;
	logic signed [ACC_W-1:0]     sum_q;

	logic                        in_band;
	logic                        at_last;
	logic [KW:0]                 kp1;
	logic signed [2*X_W-1:0]     xr;
	logic signed [KP_W-1:0]      kp;
	logic                        tdiv_start;
	logic                        rdiv_start;
	logic                        tdiv_busy;
	logic                        rdiv_busy;
	logic signed [TERM_QUO_W:0]  term_quot;
	logic signed [REC_QUO_W:0]   rec_quot;
	logic                        out_free;
	logic                        sat_hi;
	logic                        sat_lo;

	// Degree bookkeeping and shared arithmetic
	always_comb begin
		in_band = (32'(k_q) >= 32'(first_q));
		at_last = (k_q == last_q);
		kp1 = {1'b0, k_q} + (KW + 1)'(1);
		xr = xprod_q + XROUND;
		kp = $signed({1'b0, k_q}) * p_prev_q;
		sat_hi = (sum_q > SUM_HI);
		sat_lo = (sum_q < SUM_LO);
	end

	assign tdiv_start = (state_q == S_XMUL) && in_band;
	assign rdiv_start = (state_q == S_RDIV) && !at_last;
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	// Weighted term: (2k+1) P_k / (8k(k+1))
	lbws_div #(
		.NUM_W (PROD_W),
		.DEN_W (TDEN_W),
		.QUO_W (TERM_QUO_W)
	) u_term_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tdiv_start),
		.num    (tnum_q),
		.den    (tden_q),
		.busy   (tdiv_busy),
		.quot   (term_quot)
	);

	// Recurrence: ((2k+1) x P_k - k P_{k-1}) / (k+1)
	lbws_div #(
		.NUM_W (PROD_W),
		.DEN_W (KW + 1),
		.QUO_W (REC_QUO_W)
	) u_rec_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rdiv_start),
		.num    (rnum_q),
		.den    (kp1),
		.busy   (rdiv_busy),
		.quot   (rec_quot)
	);

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Set on a new result word, cleared once taken
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						case (q_head.kind)
							CMD_RUN: state_q <= S_TMUL;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_TMUL: state_q <= S_XMUL;
				S_XMUL: state_q <= S_XRND;
				S_XRND: state_q <= S_AMUL;
				S_AMUL: state_q <= S_RNUM;
				S_RNUM: state_q <= S_RDIV;
				S_RDIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (!tdiv_busy && !rdiv_busy) begin
						state_q <= at_last ? S_FIN : S_TMUL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					x_q <= q_head.x;
					first_q <= q_head.first;
					last_q <= KW'(q_head.last);
					p_prev_q <= ONE_Q30;
					p_cur_q <= q_head.x;
					k_q <= KW'(1);
					odd_q <= ODD_W'(3);
					tden_q <= TDEN_W'(16);
					sum_q <= '0;
					zero_q <= (q_head.kind == CMD_ZERO);
				end
			end
			S_TMUL: tnum_q <= $signed({1'b0, odd_q}) * p_cur_q;
			S_XMUL: xprod_q <= x_q * p_cur_q;
			// floor((x P + 2^29) / 2^30)
			S_XRND: xp_q <= xr[FRAC_W+X_W-1:FRAC_W];
			S_AMUL: a_q <= $signed({1'b0, odd_q}) * xp_q;
			S_RNUM: rnum_q <= a_q - {kp[KP_W-1], kp};
			S_WAIT: begin
				if (!tdiv_busy && !rdiv_busy) begin
					if (in_band) begin
						sum_q <= sum_q +
							{{(ACC_W - TERM_QUO_W - 1){term_quot[TERM_QUO_W]}}, term_quot};
					end
					if (!at_last) begin
						p_prev_q <= p_cur_q;
						p_cur_q <= clamp_q30(rec_quot);
						k_q <= kp1[KW-1:0];
						odd_q <= odd_q + ODD_W'(2);
						tden_q <= tden_q + TDEN_W'({kp1, 4'b0000});
					end
				end
			end
			S_FIN: begin
				// Zero sum for first multipole zero, else saturate to the output range
				if (out_free) begin
					if (zero_q) begin
						band_sum_q <= '0;
						status_q <= ST_FIRST_ZERO;
					end else if (sat_hi) begin
						band_sum_q <= SUM_HI[SUM_W-1:0];
						status_q <= ST_SAT;
					end else if (sat_lo) begin
						band_sum_q <= SUM_LO[SUM_W-1:0];
						status_q <= ST_SAT;
					end else begin
						band_sum_q <= sum_q[SUM_W-1:0];
						status_q <= ST_OK;
					end
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign band_sum = band_sum_q;
	assign status = status_q;

endmodule

[rtl/core/legendre_band_window_sum_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_band_window_sum_unit: weighted Legendre band sum
// Sum over k in [first, last] of (2k+1)/(2k(k+1)) P_k(x), x in Q1.30,
// result in Q3.28 with saturation and a status code.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           word
//  -------  ---  ------------------  ------------------------------------------
//  in       in   in_valid/in_stall   angle_cosine, first_multipole, last_multipole
//  out      out  out_valid/out_stall band_sum, status
//
//  A band is processed one degree at a time, from 1 up to the (limited) last
//  multipole; each degree waits on the bit-serial divider forming the next
//  P_k (one quotient bit per cycle), which the last degree does not start.
//  A word with first multipole zero or an empty band skips the recurrence.
//  Reset clears the sequencers, queue pointers and the result valid.
//  A stalled result holds in the output register; the front keeps taking
//  words until the command queue is full.
// ----------------------------------------------------------------------------
module legendre_band_window_sum_unit import lbws_pkg::*; #(
	parameter int MAX_MULTIPOLE = MAX_MULTIPOLE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [X_W-1:0]    angle_cosine,
	input  logic [MP_W-1:0]          first_multipole,
	input  logic [MP_W-1:0]          last_multipole,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SUM_W-1:0]  band_sum,
	output logic [ST_W-1:0]          status
);

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	cmd_t  q_cmd;
	cmd_t  q_head;

	// Classification
	lbws_front #(
		.MAX_MULTIPOLE (MAX_MULTIPOLE)
	) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.angle_cosine    (angle_cosine),
		.first_multipole (first_multipole),
		.last_multipole  (last_multipole),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_cmd           (q_cmd)
	);

	// Command queue
	lbws_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// Recurrence engine and result register
	lbws_back #(
		.MAX_MULTIPOLE (MAX_MULTIPOLE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.band_sum  (band_sum),
		.status    (status)
	);

	// Bands with first multipole zero always report a zero sum
	a_zero_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FIRST_ZERO) |-> (band_sum == '0))
		else $error("first multipole zero reported with nonzero sum");

	// Saturation flag only with an extreme value
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SAT) |->
		((band_sum == 32'sh7fff_ffff) || (band_sum == 32'sh8000_0000)))
		else $error("saturation status without saturated sum");

	// Only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_OK) || (status == ST_FIRST_ZERO) || (status == ST_SAT)))
		else $error("undefined status code");

	// Queue never pushed when full nor popped when empty
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full) && !(q_pop && q_empty))
		else $error("command queue overflow or underflow");

endmodule
